/* rtl/core/psc_pkg.sv */
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types, register codes and constants of the pressure and temperature
// compensation block.
// ----------------------------------------------------------------------------
package psc_pkg;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 64;

  typedef enum logic [1:0] {
    REG_OSS = 2'd0,
    REG_PA  = 2'd1,
    REG_PB  = 2'd2,
    REG_TC  = 2'd3
  } reg_idx_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TDIV0 = 2'd1;
  localparam logic [1:0] ST_PDIV0 = 2'd2;

  localparam logic [1:0] OSS_RESET = 2'd2;

  localparam int T_DIV_NW = 27;
  localparam int T_DIV_DW = 17;
  localparam int P_DIV_NW = 32;
  localparam int P_DIV_DW = 17;

  localparam logic signed [31:0] K_B6_OFF   = 32'sd4000;
  localparam logic signed [31:0] K_P_SQ     = 32'sd3038;
  localparam logic signed [31:0] K_P_LIN    = -32'sd77357;
  localparam logic signed [31:0] K_P_OFF    = 32'sd3791;
  localparam logic signed [31:0] K_U_OFF    = 32'sd32768;
  localparam logic        [15:0] K_B7_SCALE = 16'd50000;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [18:0] raw_pressure;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic signed [31:0] pressure_pascal;
    logic        [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  oss;
    logic [63:0] pa;
    logic [31:0] pb;
    logic [63:0] tc;
  } cfg_t;

endpackage

/* rtl/core/psc_div_pipe.sv */
// ----------------------------------------------------------------------------
// psc_div_pipe
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// side word that travels alongside each item.
// ----------------------------------------------------------------------------
module psc_div_pipe #(
  parameter int NW = 32,
  parameter int DW = 17,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [NW-1:0] in_dividend,
  input  logic [DW-1:0] in_divisor,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NW-1:0] out_quotient,
  output logic [SW-1:0] out_side
);

  logic          vld_r  [NW];
  logic [NW-1:0] dvd_r  [NW];
  logic [NW-1:0] quo_r  [NW];
  logic [DW-1:0] rem_r  [NW];
  logic [DW-1:0] dvs_r  [NW];
  logic [SW-1:0] side_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_st
    logic          vld_i;
    logic [NW-1:0] dvd_i;
    logic [NW-1:0] quo_i;
    logic [DW-1:0] rem_i;
    logic [DW-1:0] dvs_i;
    logic [SW-1:0] side_i;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign vld_i  = in_valid;
      assign dvd_i  = in_dividend;
      assign quo_i  = '0;
      assign rem_i  = '0;
      assign dvs_i  = in_divisor;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld_r[k-1];
      assign dvd_i  = dvd_r[k-1];
      assign quo_i  = quo_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign dvs_i  = dvs_r[k-1];
      assign side_i = side_r[k-1];
    end

    assign trial = {rem_i, dvd_i[NW-1]};
    assign diff  = trial - {1'b0, dvs_i};
    assign ge    = (trial >= {1'b0, dvs_i});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      dvd_r[k]  <= {dvd_i[NW-2:0], 1'b0};
      quo_r[k]  <= {quo_i[NW-2:0], ge};
      rem_r[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
      dvs_r[k]  <= dvs_i;
      side_r[k] <= side_i;
    end
  end

  assign out_valid    = vld_r[NW-1];
  assign out_quotient = quo_r[NW-1];
  assign out_side     = side_r[NW-1];

endmodule

/* rtl/core/psc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// psc_cfg_regs
// APB register file holding oversampling and calibration coefficients.
// ----------------------------------------------------------------------------
module psc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [psc_pkg::CFG_AW-1:0]  paddr,
  input  logic [psc_pkg::CFG_DW-1:0]  pwdata,
  output logic [psc_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output psc_pkg::cfg_t               cfg
);

  psc_pkg::cfg_t    cfg_r;
  psc_pkg::reg_idx_t idx;
  logic             wr_en;

  assign idx    = psc_pkg::reg_idx_t'(paddr[4:3]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.oss <= psc_pkg::OSS_RESET;
      cfg_r.pa  <= '0;
      cfg_r.pb  <= '0;
      cfg_r.tc  <= '0;
    end else if (wr_en) begin
      unique case (idx)
        psc_pkg::REG_OSS: cfg_r.oss <= pwdata[1:0];
        psc_pkg::REG_PA:  cfg_r.pa  <= pwdata;
        psc_pkg::REG_PB:  cfg_r.pb  <= pwdata[31:0];
        psc_pkg::REG_TC:  cfg_r.tc  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      psc_pkg::REG_OSS: prdata = {62'd0, cfg_r.oss};
      psc_pkg::REG_PA:  prdata = cfg_r.pa;
      psc_pkg::REG_PB:  prdata = {32'd0, cfg_r.pb};
      psc_pkg::REG_TC:  prdata = cfg_r.tc;
      default:          prdata = '0;
    endcase
  end

endmodule

/* rtl/core/pressure_sensor_compensation.sv */
// ----------------------------------------------------------------------------
// pressure_sensor_compensation
// Barometric temperature and pressure compensation, fully pipelined.
//
//   channel   ports                                   handshake
//   input     start, busy, in_item                    start & !busy
//   result    out_valid, out_item                     one-cycle strobe
//   config    psel penable pwrite paddr pwdata ...    APB, pready high
//
// One item enters every cycle; busy stays low. Each result passes through
// a 2-stage front end, the 27-stage temperature divider, seven pressure
// term stages, the 32-stage pressure divider and three final stages.
// Synchronous reset clears all valid bits.
// ----------------------------------------------------------------------------
module pressure_sensor_compensation (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  psc_pkg::in_item_t           in_item,
  output logic                        out_valid,
  output psc_pkg::out_item_t          out_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [psc_pkg::CFG_AW-1:0]  paddr,
  input  logic [psc_pkg::CFG_DW-1:0]  pwdata,
  output logic [psc_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int TNW = psc_pkg::T_DIV_NW;
  localparam int TDW = psc_pkg::T_DIV_DW;
  localparam int PNW = psc_pkg::P_DIV_NW;
  localparam int PDW = psc_pkg::P_DIV_DW;
  localparam int TSW = 17 + 19 + 2;
  localparam int PSW = 16 + 2 + 1;
  localparam int LAT = 2 + TNW + 7 + PNW + 3;

  psc_pkg::cfg_t cfg;

  psc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic        [15:0] ac4, ac5, ac6;

  assign ac1 = cfg.pa[15:0];
  assign ac2 = cfg.pa[31:16];
  assign ac3 = cfg.pa[47:32];
  assign ac4 = cfg.pa[63:48];
  assign b1  = cfg.pb[15:0];
  assign b2  = cfg.pb[31:16];
  assign ac5 = cfg.tc[15:0];
  assign ac6 = cfg.tc[31:16];
  assign mc  = cfg.tc[47:32];
  assign md  = cfg.tc[63:48];

  assign busy = 1'b0;

  logic in_fire;
  assign in_fire = start & ~busy;

  // stage 1: (ut - ac6) * ac5
  logic signed [16:0] t_diff;
  logic signed [33:0] t_prod;
  logic signed [31:0] s1_prod_r, s1_prod_nxt;
  logic        [18:0] s1_up_r;
  logic               v1_r;

  assign t_diff      = $signed({1'b0, in_item.raw_temperature}) - $signed({1'b0, ac6});
  assign t_prod      = t_diff * $signed({1'b0, ac5});
  assign s1_prod_nxt = t_prod[31:0];

  // stage 2: x1, divisor, magnitudes
  logic signed [16:0]  s2_x1_nxt, s2_x1_r;
  logic signed [17:0]  t_d;
  logic        [17:0]  t_dneg;
  logic signed [26:0]  t_num;
  logic        [26:0]  t_numneg;
  logic        [26:0]  s2_nmag_nxt, s2_nmag_r;
  logic        [16:0]  s2_dmag_nxt, s2_dmag_r;
  logic                s2_neg_nxt, s2_neg_r, s2_dz_nxt, s2_dz_r;
  logic        [18:0]  s2_up_r;
  logic                v2_r;

  always_comb begin
    s2_x1_nxt   = s1_prod_r[31:15];
    t_d         = 18'(s2_x1_nxt) + 18'(md);
    t_dneg      = -t_d;
    t_num       = {mc, 11'd0};
    t_numneg    = -t_num;
    s2_nmag_nxt = mc[15] ? t_numneg : t_num;
    s2_dmag_nxt = t_d[17] ? t_dneg[16:0] : t_d[16:0];
    s2_neg_nxt  = mc[15] ^ t_d[17];
    s2_dz_nxt   = (t_d == 18'sd0);
  end

  logic           d1_valid;
  logic [TNW-1:0] d1_quo;
  logic [TSW-1:0] d1_side;

  psc_div_pipe #(.NW(TNW), .DW(TDW), .SW(TSW)) u_tdiv (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (v2_r),
    .in_dividend  (s2_nmag_r),
    .in_divisor   (s2_dmag_r),
    .in_side      ({s2_x1_r, s2_up_r, s2_neg_r, s2_dz_r}),
    .out_valid    (d1_valid),
    .out_quotient (d1_quo),
    .out_side     (d1_side)
  );

  // stage 3: b5, temperature, b6
  logic signed [31:0] t_x1e, t_x2, t_b5, t_tb, t_tf;
  logic signed [15:0] s3_t_nxt, s3_t_r;
  logic signed [31:0] s3_b6_nxt, s3_b6_r;
  logic        [1:0]  s3_st_nxt, s3_st_r;
  logic        [18:0] s3_up_r;
  logic               v3_r;

  always_comb begin
    t_x1e     = {{15{d1_side[TSW-1]}}, d1_side[TSW-1:TSW-17]};
    t_x2      = d1_side[1] ? -$signed({5'd0, d1_quo}) : $signed({5'd0, d1_quo});
    t_b5      = t_x1e + t_x2;
    t_tb      = t_b5 + 32'sd8;
    t_tf      = t_tb >>> 4;
    if (t_tf > 32'sd32767) begin
      s3_t_nxt = 16'sh7fff;
    end else if (t_tf < -32'sd32768) begin
      s3_t_nxt = 16'sh8000;
    end else begin
      s3_t_nxt = t_tf[15:0];
    end
    s3_b6_nxt = t_b5 - psc_pkg::K_B6_OFF;
    s3_st_nxt = d1_side[0] ? psc_pkg::ST_TDIV0 : psc_pkg::ST_OK;
  end

  // stage 4: b6 products
  logic signed [63:0] t_msq;
  logic signed [47:0] t_mac2, t_mac3;
  logic signed [31:0] s4_sq_r, s4_ac2_r, s4_ac3_r;
  logic signed [15:0] s4_t_r;
  logic        [1:0]  s4_st_r;
  logic        [18:0] s4_up_r;
  logic               v4_r;

  assign t_msq  = s3_b6_r * s3_b6_r;
  assign t_mac2 = s3_b6_r * ac2;
  assign t_mac3 = s3_b6_r * ac3;

  // stage 5: shifts
  logic signed [31:0] s5_sq_r, s5_x2a_r, s5_x1b_r;
  logic signed [15:0] s5_t_r;
  logic        [1:0]  s5_st_r;
  logic        [18:0] s5_up_r;
  logic               v5_r;

  // stage 6: b2 and b1 products
  logic signed [47:0] t_mb2, t_mb1;
  logic signed [31:0] s6_mb2_r, s6_mb1_r, s6_x2a_r, s6_x1b_r;
  logic signed [15:0] s6_t_r;
  logic        [1:0]  s6_st_r;
  logic        [18:0] s6_up_r;
  logic               v6_r;

  assign t_mb2 = s5_sq_r * b2;
  assign t_mb1 = s5_sq_r * b1;

  // stage 7: b3 and the b4 operand
  logic signed [31:0] t_x1c, t_x3, t_tmp, t_sh, t_x2c, t_x3b, t_u;
  logic signed [31:0] s7_b3_nxt, s7_b3_r;
  logic        [31:0] s7_u_nxt, s7_u_r;
  logic signed [15:0] s7_t_r;
  logic        [1:0]  s7_st_r;
  logic        [18:0] s7_up_r;
  logic               v7_r;

  always_comb begin
    t_x1c     = s6_mb2_r >>> 11;
    t_x3      = t_x1c + s6_x2a_r;
    t_tmp     = $signed({{14{ac1[15]}}, ac1, 2'b00}) + t_x3;
    t_sh      = t_tmp << cfg.oss;
    s7_b3_nxt = (t_sh + 32'sd2) >>> 2;
    t_x2c     = s6_mb1_r >>> 16;
    t_x3b     = (s6_x1b_r + t_x2c + 32'sd2) >>> 2;
    t_u       = t_x3b + psc_pkg::K_U_OFF;
    s7_u_nxt  = t_u;
  end

  // stage 8: b4 product, up - b3
  logic [47:0] t_mb4;
  logic [31:0] s8_b4p_r, s8_diff_nxt, s8_diff_r;
  logic signed [15:0] s8_t_r;
  logic [1:0]  s8_st_r;
  logic        v8_r;

  assign t_mb4       = ac4 * s7_u_r;
  assign s8_diff_nxt = {13'd0, s7_up_r} - s7_b3_r;

  // stage 9: b4, b7
  logic [15:0]    t_scale;
  logic [47:0]    t_mb7;
  logic [PDW-1:0] s9_b4_r;
  logic [31:0]    s9_b7_r;
  logic signed [15:0] s9_t_r;
  logic [1:0]     s9_st_nxt, s9_st_r;
  logic           v9_r;

  assign t_scale   = psc_pkg::K_B7_SCALE >> cfg.oss;
  assign t_mb7     = s8_diff_r * t_scale;
  assign s9_st_nxt = (s8_st_r == psc_pkg::ST_OK && s8_b4p_r[31:15] == '0) ?
                     psc_pkg::ST_PDIV0 : s8_st_r;

  logic           d2_valid;
  logic [PNW-1:0] d2_quo;
  logic [PSW-1:0] d2_side;
  logic [PNW-1:0] t_dvd;

  assign t_dvd = s9_b7_r[31] ? s9_b7_r : {s9_b7_r[30:0], 1'b0};

  psc_div_pipe #(.NW(PNW), .DW(PDW), .SW(PSW)) u_pdiv (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (v9_r),
    .in_dividend  (t_dvd),
    .in_divisor   (s9_b4_r),
    .in_side      ({s9_t_r, s9_st_r, s9_b7_r[31]}),
    .out_valid    (d2_valid),
    .out_quotient (d2_quo),
    .out_side     (d2_side)
  );

  // stage 11: pressure correction products
  logic signed [31:0] t_p;
  logic signed [23:0] t_a;
  logic signed [47:0] t_maa;
  logic signed [63:0] t_m7;
  logic signed [31:0] s11_p_r, s11_aa_r, s11_m7_r;
  logic signed [15:0] s11_t_r;
  logic        [1:0]  s11_st_r;
  logic               v11_r;

  always_comb begin
    t_p   = d2_side[0] ? {d2_quo[30:0], 1'b0} : d2_quo;
    t_a   = t_p[31:8];
    t_maa = t_a * t_a;
    t_m7  = t_p * psc_pkg::K_P_LIN;
  end

  // stage 12
  logic signed [63:0] t_m3;
  logic signed [31:0] s12_p_r, s12_x1m_r, s12_x2_r;
  logic signed [15:0] s12_t_r;
  logic        [1:0]  s12_st_r;
  logic               v12_r;

  assign t_m3 = s11_aa_r * psc_pkg::K_P_SQ;

  // stage 13: final pressure
  logic signed [31:0] t_x1f, t_sum, t_pf;
  psc_pkg::out_item_t out_nxt, out_r;
  logic               out_valid_r;

  always_comb begin
    t_x1f = s12_x1m_r >>> 16;
    t_sum = t_x1f + s12_x2_r + psc_pkg::K_P_OFF;
    t_pf  = s12_p_r + (t_sum >>> 4);
    out_nxt.status             = s12_st_r;
    out_nxt.temperature_tenths = s12_t_r;
    out_nxt.pressure_pascal    = t_pf;
    if (s12_st_r == psc_pkg::ST_TDIV0) begin
      out_nxt.temperature_tenths = '0;
      out_nxt.pressure_pascal    = '0;
    end else if (s12_st_r == psc_pkg::ST_PDIV0) begin
      out_nxt.pressure_pascal    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      v8_r        <= 1'b0;
      v9_r        <= 1'b0;
      v11_r       <= 1'b0;
      v12_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= in_fire;
      v2_r        <= v1_r;
      v3_r        <= d1_valid;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      v7_r        <= v6_r;
      v8_r        <= v7_r;
      v9_r        <= v8_r;
      v11_r       <= d2_valid;
      v12_r       <= v11_r;
      out_valid_r <= v12_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_prod_r <= s1_prod_nxt;
    s1_up_r   <= in_item.raw_pressure;

    s2_x1_r   <= s2_x1_nxt;
    s2_nmag_r <= s2_nmag_nxt;
    s2_dmag_r <= s2_dmag_nxt;
    s2_neg_r  <= s2_neg_nxt;
    s2_dz_r   <= s2_dz_nxt;
    s2_up_r   <= s1_up_r;

    s3_t_r    <= s3_t_nxt;
    s3_b6_r   <= s3_b6_nxt;
    s3_st_r   <= s3_st_nxt;
    s3_up_r   <= d1_side[20:2];

    s4_sq_r   <= t_msq[31:0];
    s4_ac2_r  <= t_mac2[31:0];
    s4_ac3_r  <= t_mac3[31:0];
    s4_t_r    <= s3_t_r;
    s4_st_r   <= s3_st_r;
    s4_up_r   <= s3_up_r;

    s5_sq_r   <= s4_sq_r >>> 12;
    s5_x2a_r  <= s4_ac2_r >>> 11;
    s5_x1b_r  <= s4_ac3_r >>> 13;
    s5_t_r    <= s4_t_r;
    s5_st_r   <= s4_st_r;
    s5_up_r   <= s4_up_r;

    s6_mb2_r  <= t_mb2[31:0];
    s6_mb1_r  <= t_mb1[31:0];
    s6_x2a_r  <= s5_x2a_r;
    s6_x1b_r  <= s5_x1b_r;
    s6_t_r    <= s5_t_r;
    s6_st_r   <= s5_st_r;
    s6_up_r   <= s5_up_r;

    s7_b3_r   <= s7_b3_nxt;
    s7_u_r    <= s7_u_nxt;
    s7_t_r    <= s6_t_r;
    s7_st_r   <= s6_st_r;
    s7_up_r   <= s6_up_r;

    s8_b4p_r  <= t_mb4[31:0];
    s8_diff_r <= s8_diff_nxt;
    s8_t_r    <= s7_t_r;
    s8_st_r   <= s7_st_r;

    s9_b4_r   <= s8_b4p_r[31:15];
    s9_b7_r   <= t_mb7[31:0];
    s9_t_r    <= s8_t_r;
    s9_st_r   <= s9_st_nxt;

    s11_p_r   <= t_p;
    s11_aa_r  <= t_maa[31:0];
    s11_m7_r  <= t_m7[31:0];
    s11_t_r   <= d2_side[PSW-1:3];
    s11_st_r  <= d2_side[2:1];

    s12_p_r   <= s11_p_r;
    s12_x1m_r <= t_m3[31:0];
    s12_x2_r  <= s11_m7_r >>> 16;
    s12_t_r   <= s11_t_r;
    s12_st_r  <= s11_st_r;

    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ##LAT out_valid)
    else $error("item did not emerge after pipeline latency");

  a_tdiv0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == psc_pkg::ST_TDIV0) |->
      (out_item.temperature_tenths == 16'sd0 && out_item.pressure_pascal == 32'sd0))
    else $error("temperature divisor zero result not cleared");

  a_pdiv0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == psc_pkg::ST_PDIV0) |->
      out_item.pressure_pascal == 32'sd0)
    else $error("pressure divisor zero result not cleared");

  a_div_align: assert property (@(posedge clk) disable iff (!rst_n)
    d2_valid |-> ##3 out_valid)
    else $error("pressure divider output lost in final stages");

endmodule
